/* sv/nrmc_pkg.sv */
// ============================================================================
// NMEA RMC parser package
// Character codes, field numbers and result widths shared by the parser and
// its port checker.
// ============================================================================
package nrmc_pkg;

    localparam int UTC_W      = 36;
    localparam int LAT_W      = 40;
    localparam int LON_W      = 44;
    localparam int IN_TDATA_W = 8;
    // utc + lat + south + lon + west + fix + error = 124, padded to 128
    localparam int OUT_USED_W  = UTC_W + LAT_W + 1 + LON_W + 1 + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef logic [IN_TDATA_W-1:0]  byte_t;
    typedef logic [OUT_TDATA_W-1:0] out_data_t;

    localparam byte_t CH_DOLLAR = 8'h24;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_COMMA  = 8'h2C;
    localparam byte_t CH_M      = 8'h4D;
    localparam byte_t CH_C      = 8'h43;
    localparam byte_t CH_A      = 8'h41;
    localparam byte_t CH_S      = 8'h53;
    localparam byte_t CH_W      = 8'h57;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_NINE   = 8'h39;

    typedef logic [2:0] field_t;
    localparam field_t FLD_TIME   = 3'd1;
    localparam field_t FLD_STATUS = 3'd2;
    localparam field_t FLD_LAT    = 3'd3;
    localparam field_t FLD_NS     = 3'd4;
    localparam field_t FLD_LON    = 3'd5;
    localparam field_t FLD_EW     = 3'd6;
    localparam field_t FLD_LAST   = 3'd7;

    localparam logic [7:0] POS_HDR_M   = 8'd4;
    localparam logic [7:0] POS_HDR_C   = 8'd5;
    localparam logic [7:0] POS_HDR_END = 8'd6;
    localparam logic [7:0] POS_MAX     = 8'd255;

endpackage

/* sv/nmea_rmc_sentence_parser.sv */
// ============================================================================
// NMEA RMC sentence parser
// Takes one received character per request and emits one position result at
// the carriage return of every RMC sentence.
// ============================================================================
//
//  channel  | dir | tdata bits (low to high)
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | rx_byte[7:0]
//  m_axis   | out | utc_time_bcd, latitude_bcd, lat_south, longitude_bcd,
//           |     | lon_west, fix_valid, parse_error, 4 zero bits
//
//  One character per cycle sustained while no result is stalled. A character
//  is registered on accept in the input register and parsed once the result
//  register is free; parsing updates the sentence state and, on a carriage
//  return, loads the result register, which drives m_axis.
//  A result held by m_axis_tready stalls parsing; the input register then
//  fills and s_axis_tready drops. Reset clears all sentence state.
//
module nmea_rmc_sentence_parser #(
    parameter int TIME_DIGITS = 9,
    parameter int LAT_DIGITS  = 10,
    parameter int LON_DIGITS  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  nrmc_pkg::byte_t       s_axis_tdata,   // rx_byte[7:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [35:0] utc_time_bcd, [75:36] latitude_bcd, [76] lat_south,
    // [120:77] longitude_bcd, [121] lon_west, [122] fix_valid,
    // [123] parse_error, [127:124] zero
    output nrmc_pkg::out_data_t   m_axis_tdata
);
    import nrmc_pkg::*;

    localparam int TW   = 4 * TIME_DIGITS;
    localparam int AW   = 4 * LAT_DIGITS;
    localparam int OW   = 4 * LON_DIGITS;
    localparam int TC_W = $clog2(TIME_DIGITS + 1);
    localparam int AC_W = $clog2(LAT_DIGITS + 1);
    localparam int OC_W = $clog2(LON_DIGITS + 1);

    // input stage
    logic        in_valid_reg, in_valid_next;
    byte_t       in_byte_reg, in_byte_next;

    // sentence state
    logic        in_sentence_reg, in_sentence_next;
    logic [7:0]  char_pos_reg, char_pos_next;
    logic        hdr_match_reg, hdr_match_next;
    field_t      field_reg, field_next;
    field_t      comma_cnt_reg, comma_cnt_next;
    logic [TW-1:0]   time_reg, time_next;
    logic [TC_W-1:0] time_cnt_reg, time_cnt_next;
    logic [AW-1:0]   lat_reg, lat_next;
    logic [AC_W-1:0] lat_cnt_reg, lat_cnt_next;
    logic [OW-1:0]   lon_reg, lon_next;
    logic [OC_W-1:0] lon_cnt_reg, lon_cnt_next;
    logic        south_reg, south_next;
    logic        west_reg, west_next;
    logic        fix_reg, fix_next;

    // result stage
    logic        out_valid_reg, out_valid_next;
    out_data_t   out_data_reg, out_data_next;

    logic        out_free;
    logic        step;
    logic        is_digit;
    logic [3:0]  digit;
    byte_t       b;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign b        = in_byte_reg;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = b[3:0];

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        in_byte_next     = in_byte_reg;
        in_sentence_next = in_sentence_reg;
        char_pos_next    = char_pos_reg;
        hdr_match_next   = hdr_match_reg;
        field_next       = field_reg;
        comma_cnt_next   = comma_cnt_reg;
        time_next        = time_reg;
        time_cnt_next    = time_cnt_reg;
        lat_next         = lat_reg;
        lat_cnt_next     = lat_cnt_reg;
        lon_next         = lon_reg;
        lon_cnt_next     = lon_cnt_reg;
        south_next       = south_reg;
        west_next        = west_reg;
        fix_next         = fix_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;

        if (step)
        begin
            in_valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_axis_tdata;
        end

        if (step)
        begin
            if (b == CH_DOLLAR)
            begin
                // restart: drop whatever the old sentence collected
                in_sentence_next = 1'b1;
                char_pos_next    = 8'd1;
                hdr_match_next   = 1'b1;
                field_next       = '0;
                comma_cnt_next   = '0;
                time_next        = '0;
                time_cnt_next    = '0;
                lat_next         = '0;
                lat_cnt_next     = '0;
                lon_next         = '0;
                lon_cnt_next     = '0;
                south_next       = 1'b0;
                west_next        = 1'b0;
                fix_next         = 1'b0;
            end
            else if (in_sentence_reg)
            begin
                if (b == CH_CR)
                begin
                    in_sentence_next = 1'b0;
                    if (hdr_match_reg && (char_pos_reg >= POS_HDR_END))
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {
                            {(OUT_TDATA_W - OUT_USED_W){1'b0}},
                            (comma_cnt_reg != FLD_LAST),
                            fix_reg,
                            west_reg,
                            LON_W'(lon_reg),
                            south_reg,
                            LAT_W'(lat_reg),
                            UTC_W'(time_reg)
                        };
                    end
                end
                else
                begin
                    if ((char_pos_reg == POS_HDR_M) && (b != CH_M))
                    begin
                        hdr_match_next = 1'b0;
                    end
                    if ((char_pos_reg == POS_HDR_C) && (b != CH_C))
                    begin
                        hdr_match_next = 1'b0;
                    end
                    if (char_pos_reg != POS_MAX)
                    begin
                        char_pos_next = char_pos_reg + 8'd1;
                    end

                    if (b == CH_COMMA)
                    begin
                        // saturate at the last tracked field
                        if (comma_cnt_reg != FLD_LAST)
                        begin
                            comma_cnt_next = comma_cnt_reg + 3'd1;
                            field_next     = comma_cnt_reg + 3'd1;
                        end
                        else
                        begin
                            field_next = comma_cnt_reg;
                        end
                    end
                    else
                    begin
                        case (field_reg)
                            FLD_TIME:
                            begin
                                if (is_digit && (time_cnt_reg < TC_W'(TIME_DIGITS)))
                                begin
                                    time_next     = {time_reg[TW-5:0], digit};
                                    time_cnt_next = time_cnt_reg + TC_W'(1);
                                end
                            end
                            FLD_STATUS: fix_next = (b == CH_A);
                            FLD_LAT:
                            begin
                                if (is_digit && (lat_cnt_reg < AC_W'(LAT_DIGITS)))
                                begin
                                    lat_next     = {lat_reg[AW-5:0], digit};
                                    lat_cnt_next = lat_cnt_reg + AC_W'(1);
                                end
                            end
                            FLD_NS: south_next = (b == CH_S);
                            FLD_LON:
                            begin
                                if (is_digit && (lon_cnt_reg < OC_W'(LON_DIGITS)))
                                begin
                                    lon_next     = {lon_reg[OW-5:0], digit};
                                    lon_cnt_next = lon_cnt_reg + OC_W'(1);
                                end
                            end
                            FLD_EW: west_next = (b == CH_W);
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_sentence_reg <= 1'b0;
            char_pos_reg    <= '0;
            hdr_match_reg   <= 1'b1;
            field_reg       <= '0;
            comma_cnt_reg   <= '0;
            time_reg        <= '0;
            time_cnt_reg    <= '0;
            lat_reg         <= '0;
            lat_cnt_reg     <= '0;
            lon_reg         <= '0;
            lon_cnt_reg     <= '0;
            south_reg       <= 1'b0;
            west_reg        <= 1'b0;
            fix_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            in_sentence_reg <= in_sentence_next;
            char_pos_reg    <= char_pos_next;
            hdr_match_reg   <= hdr_match_next;
            field_reg       <= field_next;
            comma_cnt_reg   <= comma_cnt_next;
            time_reg        <= time_next;
            time_cnt_reg    <= time_cnt_next;
            lat_reg         <= lat_next;
            lat_cnt_reg     <= lat_cnt_next;
            lon_reg         <= lon_next;
            lon_cnt_reg     <= lon_cnt_next;
            south_reg       <= south_next;
            west_reg        <= west_next;
            fix_reg         <= fix_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* sv/nrmc_port_checker.sv */
// ============================================================================
// NMEA RMC parser port checker
// Watches the stream ports of the parser for stall, ordering and padding rules.
// ============================================================================
module nrmc_port_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input nrmc_pkg::byte_t      s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input nrmc_pkg::out_data_t  m_axis_tdata
);
    import nrmc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // padding above the result fields stays zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0))
        else $error("result padding not zero");

    // a fresh result must trace back to an accepted carriage return
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_CR), 2))
        else $error("result without a carriage return");

    // a held request plus a stalled result leaves no room for another request
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (!(m_axis_tvalid && !m_axis_tready) || !s_axis_tready))
        else $error("input accepted past a full pipeline");

endmodule

bind nmea_rmc_sentence_parser nrmc_port_checker u_nrmc_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/nmea_rmc_sentence_parser_tb.sv */
// ============================================================================
// NMEA RMC sentence parser testbench
// Streams received characters into the parser and predicts every position
// result in a model of its own. Each result is checked field by field,
// including the zero padding. Directed sentences cover the edge cases. A long
// random stream follows, mostly well-formed RMC sentences with random content,
// mixed with other sentence types and noise. Both stream sides idle and stall
// at random.
// ============================================================================
module nmea_rmc_sentence_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int    TIME_DIGITS = 9;
    localparam int    LAT_DIGITS  = 10;
    localparam int    LON_DIGITS  = 11;
    localparam byte_t CH_LF       = 8'h0A;

    // same bit order as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [3:0]       zero_pad;
        logic             parse_error;
        logic             fix_valid;
        logic             lon_west;
        logic [LON_W-1:0] longitude;
        logic             lat_south;
        logic [LAT_W-1:0] latitude;
        logic [UTC_W-1:0] utc_time;
    } rmc_fix_t;

    logic      clk           = 1'b0;
    logic      rst_n         = 1'b0;
    logic      s_axis_tvalid = 1'b0;
    logic      s_axis_tready;
    byte_t     s_axis_tdata  = '0;
    logic      m_axis_tvalid;
    logic      m_axis_tready = 1'b0;
    out_data_t m_axis_tdata;

    // sentence tracker state
    bit               in_frame    = 1'b0;
    logic [7:0]       char_idx    = '0;
    bit               hdr_ok      = 1'b1;
    field_t           field_idx   = '0;
    field_t           comma_total = '0;
    logic [UTC_W-1:0] utc_acc     = '0;
    logic [LAT_W-1:0] lat_acc     = '0;
    logic [LON_W-1:0] lon_acc     = '0;
    int               utc_n       = 0;
    int               lat_n       = 0;
    int               lon_n       = 0;
    bit               south_seen  = 1'b0;
    bit               west_seen   = 1'b0;
    bit               fix_letter  = 1'b0;

    rmc_fix_t fixes_due[$];
    byte_t    frame_buf[$];
    int       live_items       = 0;
    int       results_seen     = 0;
    int       mismatches       = 0;
    bit       no_gaps          = 1'b0;
    int       sink_hold_cycles = 0;

    nmea_rmc_sentence_parser #(
        .TIME_DIGITS (TIME_DIGITS),
        .LAT_DIGITS  (LAT_DIGITS),
        .LON_DIGITS  (LON_DIGITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("[nmea_rmc_sentence_parser] ERROR");
        $finish;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the sentence state by one accepted character
    function automatic void track_char(byte_t c);
        bit       is_digit;
        rmc_fix_t fix;
        if (c == CH_DOLLAR)
        begin
            in_frame    = 1'b1;
            char_idx    = 8'd1;
            hdr_ok      = 1'b1;
            field_idx   = '0;
            comma_total = '0;
            utc_acc     = '0;
            lat_acc     = '0;
            lon_acc     = '0;
            utc_n       = 0;
            lat_n       = 0;
            lon_n       = 0;
            south_seen  = 1'b0;
            west_seen   = 1'b0;
            fix_letter  = 1'b0;
            return;
        end
        if (!in_frame)
            return;
        if (c == CH_CR)
        begin
            in_frame = 1'b0;
            if (hdr_ok && char_idx >= POS_HDR_END)
            begin
                fix             = '0;
                fix.utc_time    = utc_acc;
                fix.latitude    = lat_acc;
                fix.lat_south   = south_seen;
                fix.longitude   = lon_acc;
                fix.lon_west    = west_seen;
                fix.fix_valid   = fix_letter;
                fix.parse_error = (comma_total < FLD_LAST);
                fixes_due.push_back(fix);
            end
            return;
        end
        if (char_idx == POS_HDR_M && c != CH_M)
            hdr_ok = 1'b0;
        if (char_idx == POS_HDR_C && c != CH_C)
            hdr_ok = 1'b0;
        if (char_idx != POS_MAX)
            char_idx++;
        if (c == CH_COMMA)
        begin
            if (comma_total != FLD_LAST)
                comma_total++;
            field_idx = comma_total;
            return;
        end
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        // keep the first digits, drop the rest
        case (field_idx)
            FLD_TIME:
                if (is_digit && utc_n < TIME_DIGITS)
                begin
                    utc_acc = {utc_acc[UTC_W-5:0], c[3:0]};
                    utc_n++;
                end
            FLD_STATUS: fix_letter = (c == CH_A);
            FLD_LAT:
                if (is_digit && lat_n < LAT_DIGITS)
                begin
                    lat_acc = {lat_acc[LAT_W-5:0], c[3:0]};
                    lat_n++;
                end
            FLD_NS: south_seen = (c == CH_S);
            FLD_LON:
                if (is_digit && lon_n < LON_DIGITS)
                begin
                    lon_acc = {lon_acc[LON_W-5:0], c[3:0]};
                    lon_n++;
                end
            FLD_EW: west_seen = (c == CH_W);
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [LON_W-1:0] want,
                                        logic [LON_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h",
                         results_seen, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        rmc_fix_t want;
        rmc_fix_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = rmc_fix_t'(m_axis_tdata);
            results_seen++;
            if (fixes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with none expected: %h",
                             results_seen, m_axis_tdata);
            end
            else
            begin
                want = fixes_due.pop_front();
                check_field("utc_time_bcd", LON_W'(want.utc_time),
                            LON_W'(got.utc_time));
                check_field("latitude_bcd", LON_W'(want.latitude),
                            LON_W'(got.latitude));
                check_field("lat_south", LON_W'(want.lat_south),
                            LON_W'(got.lat_south));
                check_field("longitude_bcd", want.longitude, got.longitude);
                check_field("lon_west", LON_W'(want.lon_west),
                            LON_W'(got.lon_west));
                check_field("fix_valid", LON_W'(want.fix_valid),
                            LON_W'(got.fix_valid));
                check_field("parse_error", LON_W'(want.parse_error),
                            LON_W'(got.parse_error));
                check_field("padding", LON_W'(want.zero_pad),
                            LON_W'(got.zero_pad));
            end
        end
    end

    // result side: random stalls, plus a long hold when a test asks for one
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                stall_left       = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    task automatic send_char(input byte_t c);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        live_items++;
        track_char(c);
    endtask

    function automatic void put_byte(byte_t b);
        frame_buf.push_back(b);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(byte_t'(s[i]));
    endfunction

    function automatic byte_t rand_letter();
        return CH_A + byte_t'($urandom_range(25));
    endfunction

    // digits with a dot at a random place, sometimes none
    function automatic void put_number(int n);
        int dot_at;
        dot_at = $urandom_range(0, n);
        for (int i = 0; i < n; i++)
        begin
            if (i == dot_at && $urandom_range(1))
                put_str(".");
            put_byte(CH_ZERO + byte_t'($urandom_range(9)));
        end
    endfunction

    function automatic void put_letter(byte_t hit, string other);
        case ($urandom_range(5))
            0: put_byte(hit);
            1: put_str(other);
            2: ;
            3:
            begin
                put_byte(hit);
                put_str(other);
            end
            4:
            begin
                put_str(other);
                put_byte(hit);
            end
            default: put_byte(byte_t'($urandom_range(255)));
        endcase
    endfunction

    function automatic void build_sentence(bit rmc_header);
        int nfields;
        put_byte(CH_DOLLAR);
        put_byte(rand_letter());
        put_byte(rand_letter());
        if (rmc_header)
            put_str("RMC");
        else
        begin
            put_byte(rand_letter());
            put_byte(rand_letter());
            put_byte(rand_letter());
        end
        nfields = ($urandom_range(3) == 0) ? $urandom_range(0, 9) : $urandom_range(7, 12);
        for (int f = 1; f <= nfields; f++)
        begin
            put_byte(CH_COMMA);
            case (f)
                FLD_TIME:   put_number($urandom_range(0, 12));
                FLD_STATUS: put_letter(CH_A, "V");
                FLD_LAT:    put_number($urandom_range(0, 14));
                FLD_NS:     put_letter(CH_S, "N");
                FLD_LON:    put_number($urandom_range(0, 15));
                FLD_EW:     put_letter(CH_W, "E");
                default:    put_number($urandom_range(0, 4));
            endcase
        end
        // corrupt one character now and then
        if ($urandom_range(19) == 0)
            frame_buf[$urandom_range(1, frame_buf.size() - 1)] = byte_t'($urandom_range(255));
        put_byte(CH_CR);
        if ($urandom_range(1))
            put_byte(CH_LF);
    endfunction

    task automatic send_frame();
        foreach (frame_buf[i])
            send_char(frame_buf[i]);
        frame_buf.delete();
    endtask

    task automatic send_line(string s);
        put_str(s);
        put_byte(CH_CR);
        send_frame();
    endtask

    // hold the input until every pending result is out
    task automatic wait_drained();
        if (fixes_due.size() != 0)
        begin
            s_axis_tvalid <= 1'b0;
            while (fixes_due.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_full_sentences();
        send_line("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
        send_line("$GNRMC,235959.999,A,8959.999999,S,17959.999999,W,0.0,360.0,311299,,,A*7F");
        send_line("$GPRMC,,V,,,,,,,,,,N*53");
        send_line("$GPRMC,000000.000,V,0000.000000,N,00000.000000,E,");
    endtask

    task automatic test_digit_overflow();
        send_line("$GPRMC,1234567890123.4567,A,98765432109876.5,S,123456789012345.6,W,,");
    endtask

    task automatic test_flag_letters();
        send_line("$GPRMC,1,VA,2,NS,3,EW,");
        send_line("$GPRMC,1,AV,2,SN,3,WE,");
        send_line("$GPRMC,1,a,2,s,3,w,");
    endtask

    task automatic test_header_variants();
        send_line("$");
        send_line("$GP");
        send_line("$GPRM");
        send_line("$GPRMC");
        send_line("$GPGGA,1,A,2,S,3,W,");
        send_line("$GPRMX,1,A,2,S,3,W,");
        send_line("$GPXMC,1,A,2,S,3,W,");
        send_line("$GPR,C,1,A,2,S,3,W,");
    endtask

    task automatic test_missing_commas();
        send_line("$GPRMC,1234,A,56");
        send_line("$GPRMC,");
        send_line("$GPRMC,1,A,2,S,3,W");
    endtask

    task automatic test_restart_and_noise();
        // drop everything outside a sentence
        put_str("noise");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(8'hFF);
        put_byte(8'h00);
        send_frame();
        send_line("$GPRMC,12$GPRMC,34,A,5,S,6,W,");
        put_str("$GPRMC,1");
        put_byte(8'h00);
        put_str("2,A");
        put_byte(8'hFF);
        put_str(",3");
        put_byte(8'hB9);
        put_str("4,S,5,W,");
        put_byte(CH_CR);
        send_frame();
        send_line("$GPRMC,1,A,2,S,3,W,4,5,6,7,8,9,1,2");
    endtask

    task automatic test_long_sentence();
        put_str("$GPRMC,1,A,2,N,3,W,");
        repeat (260) put_str("x");
        put_byte(CH_CR);
        send_frame();
    endtask

    task automatic test_back_pressure();
        no_gaps = 1'b1;
        sink_hold_cycles = 400;
        repeat (2) send_line("$GPRMC,235959.999,A,8959.999999,S,17959.999999,W,1.0,2.0,010100,,");
        no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            build_sentence(1'b1);
            send_frame();
            wait_drained();
        end
    endtask

    task automatic test_random_stream();
        int first_item;
        int r;
        first_item = live_items;
        while (live_items - first_item < 250)
        begin
            no_gaps = ($urandom_range(9) == 0);
            r = $urandom_range(99);
            if (r < 75)
                build_sentence(1'b1);
            else if (r < 87)
                build_sentence(1'b0);
            else
            begin
                if ($urandom_range(2) == 0)
                    put_byte(CH_DOLLAR);
                repeat ($urandom_range(1, 30)) put_byte(byte_t'($urandom_range(255)));
                if ($urandom_range(1))
                    put_byte(CH_CR);
            end
            send_frame();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_full_sentences();
        test_digit_overflow();
        test_flag_letters();
        test_header_variants();
        test_missing_commas();
        test_restart_and_noise();
        test_long_sentence();
        test_back_pressure();
        test_drain_pause();
        test_random_stream();
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 50000 && fixes_due.size() != 0; n++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fixes_due.size() != 0)
            $display("%0d expected results never arrived", fixes_due.size());
        if (mismatches == 0 && fixes_due.size() == 0)
            $display("[nmea_rmc_sentence_parser] OK");
        else
            $display("[nmea_rmc_sentence_parser] ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/nrmc_pkg.sv
sv/nmea_rmc_sentence_parser.sv
sv/nrmc_port_checker.sv
tb/nmea_rmc_sentence_parser_tb.sv
